### sv/sra_pkg.sv
// Shared definitions for the reference-counted slot allocator.
// Holds command and status codes, default sizes and the memory control struct.
// No dependencies; every other file of the block refers to this package.
package sra_pkg;

  localparam int SLOTS_DEF    = 256;
  localparam int REF_BITS_DEF = 16;

  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;
  localparam int SLOT_W      = 8;
  localparam int DATA_W      = 32;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_REF   = 2'd1;
  localparam logic [1:0] CMD_DEREF = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_UNUSED = 2'd3;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

### sv/sra_mem.sv
// Slot table memory: one write port, one read port, registered read data.
// Depends on sra_pkg for the control struct.
module sra_mem #(
  parameter int DEPTH = sra_pkg::SLOTS_DEF,
  parameter int AW    = 8,
  parameter int DW    = sra_pkg::REF_BITS_DEF + 33
) (
  input  logic             clk,
  input  sra_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]    wr_addr,
  input  logic [DW-1:0]    wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [DW-1:0]    rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/sra_ctrl.sv
// Command sequencer of the slot allocator: read-modify-write of slot entries,
// the allocation scan, the table counters and the output register.
// Depends on sra_pkg and drives the port of sra_mem.
module sra_ctrl #(
  parameter int SLOTS    = sra_pkg::SLOTS_DEF,
  parameter int REF_BITS = sra_pkg::REF_BITS_DEF,
  parameter int IDX_W    = $clog2(SLOTS),
  parameter int DW       = REF_BITS + 33
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_cmd,
  input  logic [sra_pkg::SLOT_W-1:0] in_slot,
  input  logic [sra_pkg::DATA_W-1:0] in_first,
  input  logic [sra_pkg::DATA_W-1:0] in_count,
  input  logic                       in_entry_valid,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sra_pkg::SLOT_W-1:0] out_slot,
  output logic [sra_pkg::DATA_W-1:0] out_sub,
  output logic [1:0]                 out_status,
  output sra_pkg::mem_ctl_t          mem_ctl,
  output logic [IDX_W-1:0]           mem_wr_addr,
  output logic [DW-1:0]              mem_wr_data,
  output logic [IDX_W-1:0]           mem_rd_addr,
  input  logic [DW-1:0]              mem_rd_data
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > sra_pkg::SLOT_W) ? CNT_W : sra_pkg::SLOT_W;
  localparam logic [REF_BITS-1:0] REF_MAX = {1'b0, {(REF_BITS-1){1'b1}}};
  localparam logic [REF_BITS-1:0] REF_MIN = {1'b1, {(REF_BITS-1){1'b0}}};
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

  typedef enum logic [1:0] {S_IDLE, S_RMW, S_SCAN, S_EMIT} state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] hint_r, hint_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic [sra_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [sra_pkg::DATA_W-1:0] first_r, first_nxt;
  logic [sra_pkg::DATA_W-1:0] cnt_r, cnt_nxt;
  logic valid_r, valid_nxt;

  logic out_valid_r;
  logic [sra_pkg::SLOT_W-1:0] out_slot_r;
  logic [sra_pkg::DATA_W-1:0] out_sub_r;
  logic [1:0] out_st_r;
  logic [sra_pkg::SLOT_W-1:0] pend_slot_r;
  logic [sra_pkg::DATA_W-1:0] pend_sub_r;
  logic [1:0] pend_st_r;

  logic [1:0] cur_cmd;
  logic [sra_pkg::SLOT_W-1:0] cur_slot;
  logic [sra_pkg::DATA_W-1:0] cur_first;
  logic [sra_pkg::DATA_W-1:0] cur_cnt;
  logic cur_valid;
  logic [CMP_W-1:0] cur_slot_ext;
  logic [IDX_W-1:0] cur_idx;
  logic in_range;

  logic rd_live;
  logic [sra_pkg::DATA_W-1:0] rd_stored;
  logic [REF_BITS-1:0] rd_ref;
  logic [REF_BITS-1:0] new_ref;
  logic [sra_pkg::DATA_W-1:0] avail;
  logic [CNT_W-1:0] hint_inc;
  logic [CMP_W-1:0] idx_wide;

  logic out_free;
  logic fin;
  logic do_tail;
  logic [CMP_W-1:0] res_slot;
  logic [sra_pkg::DATA_W-1:0] res_sub;
  logic [1:0] res_st;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  assign cur_cmd      = (state_r == S_IDLE) ? in_cmd : cmd_r;
  assign cur_slot     = (state_r == S_IDLE) ? in_slot : slot_r;
  assign cur_first    = (state_r == S_IDLE) ? in_first : first_r;
  assign cur_cnt      = (state_r == S_IDLE) ? in_count : cnt_r;
  assign cur_valid    = (state_r == S_IDLE) ? in_entry_valid : valid_r;
  assign cur_slot_ext = CMP_W'(cur_slot);
  assign cur_idx      = cur_slot_ext[IDX_W-1:0];
  assign in_range     = cur_slot_ext < CMP_W'(used_r);

  assign rd_live   = mem_rd_data[REF_BITS+32];
  assign rd_stored = mem_rd_data[REF_BITS+31:REF_BITS];
  assign rd_ref    = mem_rd_data[REF_BITS-1:0];
  assign avail     = rd_stored - cur_first;
  assign hint_inc  = hint_r + CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    hint_nxt    = hint_r;
    cmd_nxt     = cmd_r;
    slot_nxt    = slot_r;
    first_nxt   = first_r;
    cnt_nxt     = cnt_r;
    valid_nxt   = valid_r;
    mem_ctl     = '0;
    mem_rd_addr = '0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    new_ref     = rd_ref;
    idx_wide    = '0;
    fin         = 1'b0;
    do_tail     = 1'b0;
    res_slot    = '0;
    res_sub     = '0;
    res_st      = sra_pkg::ST_OK;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          slot_nxt  = in_slot;
          first_nxt = in_first;
          cnt_nxt   = in_count;
          valid_nxt = in_entry_valid;
          case (cur_cmd)
            sra_pkg::CMD_ALLOC: begin
              if (hint_r < used_r) begin
                mem_ctl.rd  = 1'b1;
                mem_rd_addr = hint_r[IDX_W-1:0];
                state_nxt   = S_SCAN;
              end else begin
                do_tail = 1'b1;
              end
            end
            sra_pkg::CMD_REF, sra_pkg::CMD_DEREF: begin
              if (in_range) begin
                mem_ctl.rd  = 1'b1;
                mem_rd_addr = cur_idx;
                state_nxt   = S_RMW;
              end else begin
                fin      = 1'b1;
                res_slot = cur_slot_ext;
                res_sub  = (cur_cmd == sra_pkg::CMD_REF) ? cur_cnt : '0;
                res_st   = sra_pkg::ST_RANGE;
              end
            end
            default: begin
              used_nxt = '0;
              hint_nxt = '0;
              fin      = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_ref[REF_BITS-1] || (rd_ref == '0)) begin
          mem_ctl.wr  = 1'b1;
          mem_wr_addr = hint_r[IDX_W-1:0];
          mem_wr_data = {cur_valid, cur_cnt, {REF_BITS{1'b0}}};
          fin         = 1'b1;
          res_slot    = CMP_W'(hint_r);
        end else if (hint_inc < used_r) begin
          hint_nxt    = hint_inc;
          mem_ctl.rd  = 1'b1;
          mem_rd_addr = hint_inc[IDX_W-1:0];
        end else begin
          hint_nxt = used_r;
          do_tail  = 1'b1;
        end
      end
      S_RMW: begin
        fin      = 1'b1;
        res_slot = cur_slot_ext;
        mem_ctl.wr  = 1'b1;
        mem_wr_addr = cur_idx;
        if (cur_cmd == sra_pkg::CMD_REF) begin
          if (rd_ref != REF_MAX) begin
            new_ref = rd_ref + REF_BITS'(1);
          end
          res_sub     = (rd_live && (avail < cur_cnt)) ? avail : cur_cnt;
          mem_wr_data = {rd_live, rd_stored, new_ref};
        end else begin
          if (rd_ref != REF_MIN) begin
            new_ref = rd_ref - REF_BITS'(1);
          end
          if (new_ref[REF_BITS-1] || (new_ref == '0)) begin
            mem_wr_data = {1'b0, rd_stored, new_ref};
            if (cur_slot_ext < CMP_W'(hint_r)) begin
              hint_nxt = cur_slot_ext[CNT_W-1:0];
            end
          end else begin
            mem_wr_data = {rd_live, rd_stored, new_ref};
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_tail) begin
      fin = 1'b1;
      if (used_r == FULL_CNT) begin
        res_st = sra_pkg::ST_FULL;
      end else begin
        idx_wide    = CMP_W'(used_r);
        mem_ctl.wr  = 1'b1;
        mem_wr_addr = idx_wide[IDX_W-1:0];
        mem_wr_data = {cur_valid, cur_cnt, {REF_BITS{1'b0}}};
        used_nxt    = used_r + CNT_W'(1);
        hint_nxt    = used_r + CNT_W'(1);
        res_slot    = idx_wide;
      end
    end

    if (fin) begin
      state_nxt = out_free ? S_IDLE : S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      hint_r    <= hint_nxt;
      cmd_r     <= cmd_nxt;
      slot_r    <= slot_nxt;
      first_r   <= first_nxt;
      cnt_r     <= cnt_nxt;
      valid_r   <= valid_nxt;
      if (fin && out_free) begin
        out_valid_r <= 1'b1;
        out_slot_r  <= res_slot[sra_pkg::SLOT_W-1:0];
        out_sub_r   <= res_sub;
        out_st_r    <= res_st;
      end else if ((state_r == S_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
        out_slot_r  <= pend_slot_r;
        out_sub_r   <= pend_sub_r;
        out_st_r    <= pend_st_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (fin && !out_free) begin
        pend_slot_r <= res_slot[sra_pkg::SLOT_W-1:0];
        pend_sub_r  <= res_sub;
        pend_st_r   <= res_st;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_slot   = out_slot_r;
  assign out_sub    = out_sub_r;
  assign out_status = out_st_r;

endmodule

### sv/refcounted_slot_allocator_unit.sv
// Top level of the reference-counted slot allocator.
// Depends on sra_pkg, sra_mem and sra_ctrl.
//
// The block keeps a table of slots, each with a signed reference count, a
// stored index count and a live bit, in one synchronous memory. Commands
// arrive on the in_ stream (cmd in in_tuser) and each gives exactly one
// result item on the out_ stream (status in out_tuser).
// One command is worked on at a time; in_tready is high while the sequencer
// is idle. Clear and out-of-range requests finish in the idle state, as do
// a full table and an append when no scan is needed; reference and
// dereference read the memory, then write back. Allocation reads one entry
// per cycle from the free hint until it finds a slot to reuse, and ends in
// an append or a full table when the scan reaches the used count.
// The result sits in an output register; when the receiver stalls, one more
// result is held inside and the block stops accepting until it drains.
// Reset empties the table at once: the counters and the hint go to zero and
// no memory pass is needed, since only entries below the used count are read.
module refcounted_slot_allocator_unit #(
  parameter int SLOTS    = sra_pkg::SLOTS_DEF,
  parameter int REF_BITS = sra_pkg::REF_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // slot[7:0], first_index[39:8], count[71:40], entry_valid[72], zero[79:73]
  input  logic [sra_pkg::IN_TDATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [sra_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // slot_out[7:0], sub_count[39:8]
  output logic [sra_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [sra_pkg::OUT_TUSER_W-1:0] out_tuser
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int DW    = REF_BITS + 33;

  sra_pkg::mem_ctl_t mem_ctl;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [IDX_W-1:0] mem_rd_addr;
  logic [DW-1:0] mem_wr_data;
  logic [DW-1:0] mem_rd_data;
  logic [sra_pkg::SLOT_W-1:0] out_slot;
  logic [sra_pkg::DATA_W-1:0] out_sub;

  sra_mem #(
    .DEPTH (SLOTS),
    .AW    (IDX_W),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  sra_ctrl #(
    .SLOTS    (SLOTS),
    .REF_BITS (REF_BITS),
    .IDX_W    (IDX_W),
    .DW       (DW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_cmd         (in_tuser[1:0]),
    .in_slot        (in_tdata[7:0]),
    .in_first       (in_tdata[39:8]),
    .in_count       (in_tdata[71:40]),
    .in_entry_valid (in_tdata[72]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_slot       (out_slot),
    .out_sub        (out_sub),
    .out_status     (out_tuser),
    .mem_ctl        (mem_ctl),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  assign out_tdata = {out_sub, out_slot};

endmodule

### sv/sra_checker.sv
// Port-level checks for the slot allocator and the bind that attaches them.
// Depends on sra_pkg and on the top level refcounted_slot_allocator_unit.
module sra_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sra_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [sra_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // A result never carries the unused status code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != sra_pkg::ST_UNUSED))
    else $error("result with unused status code");

  // A full table reports slot zero and a zero count.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == sra_pkg::ST_FULL)) |-> (out_tdata == '0))
    else $error("full status with nonzero payload");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  // No result is offered in the cycle after a reset cycle.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // A command accepted while a result is stalled stops further input until
  // the stalled result has moved.
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready || !$past(out_tvalid && !out_tready)
      || !out_tvalid)
    else $error("command accepted while results back up");

endmodule

bind refcounted_slot_allocator_unit sra_checker u_sra_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### verif/tb_refcounted_slot_allocator_unit.sv
// Self-checking testbench for refcounted_slot_allocator_unit: a scoreboard class
// predicts every result item from its own copy of the slot table and checks the
// out_ stream in order. Depends on sra_pkg and the block's RTL only.
module tb_refcounted_slot_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = sra_pkg::SLOTS_DEF;
  // A narrow count width lets bursts of references reach both saturation limits.
  localparam int REF_W = 4;
  localparam int REF_HI = 2 ** (REF_W - 1) - 1;
  localparam int REF_LO = -(2 ** (REF_W - 1));
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 625;

  typedef struct packed {
    logic [7:0]  slot;
    logic [31:0] sub;
    logic [1:0]  status;
  } slot_result_t;

  class slot_table_scoreboard;
    logic signed [REF_W-1:0] refs [SLOTS];
    logic [31:0] stored [SLOTS];
    bit live [SLOTS];
    int used;
    int hint;
    slot_result_t expected [$];
    logic [1:0] last_status;
    int errors;
    int n_items;
    int n_results;
    int n_full;
    int n_range;
    int n_ceiling;
    int n_floor;
    int n_cmd [4];

    function void note_input(logic [1:0] cmd, logic [7:0] slot, logic [31:0] first,
                             logic [31:0] cnt, logic valid);
      slot_result_t r;
      logic [31:0] avail;
      int s;
      r = '{slot: 8'd0, sub: 32'd0, status: sra_pkg::ST_OK};
      s = int'(slot);
      n_items++;
      n_cmd[cmd]++;
      case (cmd)
        sra_pkg::CMD_ALLOC: begin
          while (hint < used && refs[hint] > 0) hint++;
          if (hint < used) begin
            refs[hint] = '0;
            stored[hint] = cnt;
            live[hint] = valid;
            r.slot = hint[7:0];
          end else if (used >= SLOTS) begin
            r.status = sra_pkg::ST_FULL;
            n_full++;
          end else begin
            refs[used] = '0;
            stored[used] = cnt;
            live[used] = valid;
            r.slot = used[7:0];
            used++;
            hint = used;
          end
        end
        sra_pkg::CMD_REF: begin
          r.slot = slot;
          r.sub = cnt;
          if (s >= used) begin
            r.status = sra_pkg::ST_RANGE;
            n_range++;
          end else begin
            if (int'(refs[s]) < REF_HI) refs[s]++;
            else n_ceiling++;
            if (live[s]) begin
              avail = stored[s] - first;
              if (avail < cnt) r.sub = avail;
            end
          end
        end
        sra_pkg::CMD_DEREF: begin
          r.slot = slot;
          if (s >= used) begin
            r.status = sra_pkg::ST_RANGE;
            n_range++;
          end else begin
            if (int'(refs[s]) > REF_LO) refs[s]--;
            else n_floor++;
            if (refs[s] <= 0) begin
              live[s] = 1'b0;
              if (s < hint) hint = s;
            end
          end
        end
        sra_pkg::CMD_CLEAR: begin
          foreach (live[i]) live[i] = 1'b0;
          used = 0;
          hint = 0;
        end
        default: begin
        end
      endcase
      last_status = r.status;
      expected.push_back(r);
    endfunction

    function void check_result(logic [7:0] slot, logic [31:0] sub, logic [1:0] status);
      slot_result_t want;
      n_results++;
      if (expected.size() == 0) begin
        $error("unexpected result item: slot_out %0d sub_count %0d status %0d",
               slot, sub, status);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (slot !== want.slot) begin
        $error("slot_out: expected %0d, actual %0d", want.slot, slot);
        errors++;
      end
      if (sub !== want.sub) begin
        $error("sub_count: expected 0x%08h, actual 0x%08h", want.sub, sub);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [sra_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [sra_pkg::IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [sra_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [sra_pkg::OUT_TUSER_W-1:0] out_tuser;

  bit sender_steady = 1'b0;
  slot_table_scoreboard table_sb = new;

  refcounted_slot_allocator_unit #(
    .SLOTS(SLOTS),
    .REF_BITS(REF_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 100));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_slot();
    if (table_sb.used > 0 && $urandom_range(0, 99) < 80)
      return 8'($urandom_range(0, table_sb.used - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [7:0] slot, logic [31:0] first,
                           logic [31:0] cnt, logic valid);
    if (!sender_steady && $urandom_range(0, 99) < 26) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {7'd0, valid, cnt, first, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    table_sb.note_input(cmd, slot, first, cnt, valid);
  endtask

  task automatic mixed_run(int n);
    int pick;
    logic [1:0] cmd;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) cmd = sra_pkg::CMD_CLEAR;
      else if (pick < 38) cmd = sra_pkg::CMD_ALLOC;
      else if (pick < 70) cmd = sra_pkg::CMD_REF;
      else cmd = sra_pkg::CMD_DEREF;
      send_item(cmd, pick_slot(), rand_word(), rand_word(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic burst_run();
    logic [7:0] s;
    logic [1:0] op;
    s = pick_slot();
    op = $urandom_range(0, 1) ? sra_pkg::CMD_REF : sra_pkg::CMD_DEREF;
    repeat ($urandom_range(9, 18))
      send_item(op, s, rand_word(), rand_word(), 1'($urandom_range(0, 1)));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      table_sb.check_result(out_tdata[7:0], out_tdata[39:8], out_tuser);
  end

  initial begin
    bit held;
    bit calm;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && table_sb.n_results >= 40) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      calm = table_sb.n_results >= 200 && table_sb.n_results < 320;
      out_tready <= calm || $urandom_range(0, 99) >= 26;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(sra_pkg::CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(sra_pkg::CMD_REF, 8'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_item(sra_pkg::CMD_DEREF, 8'hFF, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_item(sra_pkg::CMD_ALLOC, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(sra_pkg::CMD_ALLOC, 8'd0, 32'd0, 32'd0, 1'b0);
    send_item(sra_pkg::CMD_ALLOC, 8'd0, 32'd0, 32'd100, 1'b1);
    send_item(sra_pkg::CMD_REF, 8'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
    // The stored count minus the first index wraps, so the request stands.
    send_item(sra_pkg::CMD_REF, 8'd2, 32'd200, 32'd50, 1'b0);
    send_item(sra_pkg::CMD_REF, 8'd2, 32'd30, 32'd1000, 1'b0);
    send_item(sra_pkg::CMD_REF, 8'd1, 32'd5, 32'd7, 1'b0);
    send_item(sra_pkg::CMD_DEREF, 8'd1, 32'd0, 32'd0, 1'b0);
    send_item(sra_pkg::CMD_DEREF, 8'd0, 32'd0, 32'd0, 1'b0);
    send_item(sra_pkg::CMD_ALLOC, 8'd0, 32'd0, 32'd9, 1'b1);
    send_item(sra_pkg::CMD_ALLOC, 8'd0, 32'd0, 32'd11, 1'b0);
    send_item(sra_pkg::CMD_REF, 8'd0, 32'd3, 32'd4, 1'b0);
    send_item(sra_pkg::CMD_ALLOC, 8'd0, 32'd0, 32'd12, 1'b1);
    send_item(sra_pkg::CMD_REF, 8'd1, 32'hFFFF_FFFF, 32'd1, 1'b0);
    send_item(sra_pkg::CMD_ALLOC, 8'd0, 32'd0, 32'd13, 1'b1);
    send_item(sra_pkg::CMD_REF, 8'd3, 32'd13, 32'd5, 1'b0);
    send_item(sra_pkg::CMD_DEREF, 8'd4, 32'd0, 32'd0, 1'b0);
    send_item(sra_pkg::CMD_REF, 8'd200, 32'd1, 32'd2, 1'b0);
    send_item(sra_pkg::CMD_CLEAR, 8'd0, 32'd0, 32'd0, 1'b0);
    send_item(sra_pkg::CMD_ALLOC, 8'd0, 32'd0, 32'd1, 1'b1);

    while (table_sb.n_items < 150) begin
      if ($urandom_range(0, 3) == 0) burst_run();
      else mixed_run(12);
    end

    // Fill the whole table back to back, then keep allocating into a full table.
    sender_steady = 1'b1;
    send_item(sra_pkg::CMD_CLEAR, pick_slot(), rand_word(), rand_word(), 1'b0);
    while (table_sb.last_status != sra_pkg::ST_FULL)
      send_item(sra_pkg::CMD_ALLOC, pick_slot(), rand_word(), rand_word(),
                1'($urandom_range(0, 1)));
    repeat (2)
      send_item(sra_pkg::CMD_ALLOC, pick_slot(), rand_word(), rand_word(),
                1'($urandom_range(0, 1)));
    sender_steady = 1'b0;

    in_tvalid <= 1'b0;
    while (table_sb.pending() != 0) @(posedge clk);

    while (table_sb.n_items < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 3) burst_run();
      else mixed_run(12);
    end

    in_tvalid <= 1'b0;
    while (table_sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d allocations (%0d into a full table), %0d references,",
             table_sb.n_cmd[sra_pkg::CMD_ALLOC], table_sb.n_full,
             table_sb.n_cmd[sra_pkg::CMD_REF]);
    $display("%0d dereferences, %0d clears, %0d out-of-range, %0d ceiling and %0d floor hits.",
             table_sb.n_cmd[sra_pkg::CMD_DEREF], table_sb.n_cmd[sra_pkg::CMD_CLEAR],
             table_sb.n_range, table_sb.n_ceiling, table_sb.n_floor);
    if (table_sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
